### src/lzrle_pkg.sv
package lzrle_pkg;

  localparam int DEF_HISTORY_BYTES = 16384;
  localparam int DEF_RESULT_BYTES  = 32;
  localparam logic [14:0] DEF_MAX_OUTPUT = 15'd16384;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam int OUT_TDATA_W = 296;
  localparam int LANE_BITS   = 256;

  localparam logic [2:0] ST_BUSY  = 3'd0;
  localparam logic [2:0] ST_DONE  = 3'd1;
  localparam logic [2:0] ST_TRUNC = 3'd2;
  localparam logic [2:0] ST_OVER  = 3'd3;
  localparam logic [2:0] ST_LOW   = 3'd4;
  localparam logic [2:0] ST_HIGH  = 3'd5;

  localparam logic [2:0] K_NONE = 3'd0;
  localparam logic [2:0] K_LIT  = 3'd1;
  localparam logic [2:0] K_FILL = 3'd2;
  localparam logic [2:0] K_PAIR = 3'd3;
  localparam logic [2:0] K_INC  = 3'd4;
  localparam logic [2:0] K_FWD  = 3'd5;
  localparam logic [2:0] K_REV  = 3'd6;
  localparam logic [2:0] K_BACK = 3'd7;

  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] len;
    logic [7:0]  val_a;
    logic [7:0]  val_b;
    logic [15:0] addr;
    logic [2:0]  status;
    logic [15:0] consumed;
    logic [14:0] decompressed;
  } lzrle_job_t;

  function automatic logic [7:0] bitrev8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[7 - i];
    end
    return r;
  endfunction

endpackage

### src/lzrle_front.sv
module lzrle_front import lzrle_pkg::*; #(
  parameter int HISTORY_BYTES = DEF_HISTORY_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [14:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        in_ready,
  input  logic        q_full,
  output logic        push,
  output lzrle_job_t  job
);

  localparam int CW = $clog2(HISTORY_BYTES + 1);
  localparam int SW = ((CW > 16) ? CW : 16) + 1;

  localparam logic [2:0] PH_CTRL = 3'd0;
  localparam logic [2:0] PH_EXT  = 3'd1;
  localparam logic [2:0] PH_LIT  = 3'd2;
  localparam logic [2:0] PH_ARG1 = 3'd3;
  localparam logic [2:0] PH_ARG2 = 3'd4;
  localparam logic [2:0] PH_STOP = 3'd5;

  localparam logic [2:0] CMD_LIT  = 3'd0;
  localparam logic [2:0] CMD_FILL = 3'd1;
  localparam logic [2:0] CMD_PAIR = 3'd2;
  localparam logic [2:0] CMD_INC  = 3'd3;
  localparam logic [2:0] CMD_FWD  = 3'd4;
  localparam logic [2:0] CMD_REV  = 3'd5;
  localparam logic [2:0] CMD_BACK = 3'd6;
  localparam logic [2:0] CMD_EXT  = 3'd7;

  logic [14:0]   max_r;
  logic [2:0]    phase_r, phase_nxt;
  logic [2:0]    cmd_r, cmd_nxt;
  logic [10:0]   rl_r, rl_nxt;
  logic [7:0]    af_r, af_nxt;
  logic [CW-1:0] oc_r, oc_nxt;
  logic [15:0]   src_r, src_nxt;
  logic [2:0]    status_r, status_nxt;

  logic          start_en;
  logic [2:0]    start_cmd;
  logic [10:0]   start_len;
  logic [11:0]   produce;
  logic [SW-1:0] lim;
  logic [15:0]   addr;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;
  assign addr     = {af_r, in_byte};
  assign lim      = (SW'(max_r) < SW'(HISTORY_BYTES)) ? SW'(max_r) : SW'(HISTORY_BYTES);

  always_comb begin
    phase_nxt  = phase_r;
    cmd_nxt    = cmd_r;
    rl_nxt     = rl_r;
    af_nxt     = af_r;
    src_nxt    = src_r;
    status_nxt = status_r;
    start_en   = 1'b0;
    start_cmd  = cmd_r;
    start_len  = rl_r;
    produce    = 12'd0;
    job        = '0;
    job.kind   = K_NONE;
    job.val_a  = in_byte;
    job.addr   = addr;
    if (phase_r != PH_STOP) begin
      if (src_r != 16'hFFFF) begin
        src_nxt = src_r + 16'd1;
      end
      case (phase_r)
        PH_CTRL: begin
          if (in_byte == 8'hFF) begin
            status_nxt = ST_DONE;
          end else if (in_byte[7:5] == CMD_EXT) begin
            cmd_nxt   = (in_byte[4:2] == CMD_EXT) ? CMD_FWD : in_byte[4:2];
            rl_nxt    = {1'b0, in_byte[1:0], 8'h00};
            phase_nxt = PH_EXT;
          end else begin
            start_en  = 1'b1;
            start_cmd = in_byte[7:5];
            start_len = 11'(in_byte[4:0]) + 11'd1;
          end
        end
        PH_EXT: begin
          start_en  = 1'b1;
          start_cmd = cmd_r;
          start_len = 11'({rl_r[9:8], in_byte}) + 11'd1;
        end
        PH_LIT: begin
          job.kind = K_LIT;
          job.len  = 12'd1;
          rl_nxt   = rl_r - 11'd1;
          if (rl_r == 11'd1) begin
            phase_nxt = PH_CTRL;
          end
        end
        PH_ARG1: begin
          af_nxt = in_byte;
          if (cmd_r == CMD_FILL || cmd_r == CMD_INC) begin
            job.kind  = (cmd_r == CMD_FILL) ? K_FILL : K_INC;
            job.len   = 12'(rl_r);
            phase_nxt = PH_CTRL;
          end else begin
            phase_nxt = PH_ARG2;
          end
        end
        PH_ARG2: begin
          job.val_a = af_r;
          job.val_b = in_byte;
          if (cmd_r == CMD_PAIR) begin
            job.kind  = K_PAIR;
            job.len   = {rl_r, 1'b0};
            phase_nxt = PH_CTRL;
          end else if (cmd_r == CMD_BACK) begin
            if (SW'(addr) < SW'(rl_r) - SW'(1)) begin
              status_nxt = ST_LOW;
            end else if (SW'(addr) >= SW'(oc_r)) begin
              status_nxt = ST_HIGH;
            end else begin
              job.kind  = K_BACK;
              job.len   = 12'(rl_r);
              phase_nxt = PH_CTRL;
            end
          end else begin
            if (SW'(addr) + SW'(rl_r) > SW'(oc_r)) begin
              status_nxt = ST_HIGH;
            end else begin
              job.kind  = (cmd_r == CMD_REV) ? K_REV : K_FWD;
              job.len   = 12'(rl_r);
              phase_nxt = PH_CTRL;
            end
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
      if (start_en) begin
        produce = (start_cmd == CMD_PAIR) ? {start_len, 1'b0} : {1'b0, start_len};
        if (SW'(oc_r) + SW'(produce) > lim) begin
          status_nxt = ST_OVER;
        end else begin
          cmd_nxt   = start_cmd;
          rl_nxt    = start_len;
          phase_nxt = (start_cmd == CMD_LIT) ? PH_LIT : PH_ARG1;
        end
      end
      if (status_nxt == ST_BUSY && in_last) begin
        status_nxt = ST_TRUNC;
      end
      if (status_nxt != ST_BUSY) begin
        phase_nxt = PH_STOP;
      end
    end
    oc_nxt           = CW'(SW'(oc_r) + SW'(job.len));
    job.status       = status_nxt;
    job.consumed     = src_nxt;
    job.decompressed = 15'(oc_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r    <= DEF_MAX_OUTPUT;
      phase_r  <= PH_CTRL;
      cmd_r    <= CMD_LIT;
      rl_r     <= '0;
      af_r     <= '0;
      oc_r     <= '0;
      src_r    <= '0;
      status_r <= ST_BUSY;
    end else begin
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
      if (push) begin
        phase_r  <= phase_nxt;
        cmd_r    <= cmd_nxt;
        rl_r     <= rl_nxt;
        af_r     <= af_nxt;
        oc_r     <= oc_nxt;
        src_r    <= src_nxt;
        status_r <= status_nxt;
      end
    end
  end

endmodule

### src/lzrle_queue.sv
module lzrle_queue import lzrle_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  lzrle_job_t push_job,
  input  logic       pop,
  output lzrle_job_t head,
  output logic       full,
  output logic       empty
);

  lzrle_job_t     slot_r [QDEPTH];
  logic [QAW-1:0] wptr_r;
  logic [QAW-1:0] rptr_r;
  logic [QAW:0]   cnt_r;

  assign head  = slot_r[rptr_r];
  assign full  = (cnt_r == (QAW + 1)'(QDEPTH));
  assign empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + QAW'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + QAW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (QAW + 1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (QAW + 1)'(1);
      end
    end
  end

endmodule

### src/lzrle_back.sv
module lzrle_back import lzrle_pkg::*; #(
  parameter int HISTORY_BYTES = DEF_HISTORY_BYTES,
  parameter int RESULT_BYTES  = DEF_RESULT_BYTES
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lzrle_job_t                head,
  input  logic                      q_empty,
  output logic                      pop,
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic [RESULT_BYTES*8-1:0] res_data,
  output logic [5:0]                res_count,
  output logic                      res_last,
  output logic [2:0]                res_status,
  output logic [15:0]               res_consumed,
  output logic [14:0]               res_decompressed
);

  localparam int AW = $clog2(HISTORY_BYTES);
  localparam int FW = $clog2(RESULT_BYTES + 1);
  localparam int IW = $clog2(RESULT_BYTES);

  logic [7:0]    hist_mem [HISTORY_BYTES];
  logic [7:0]    chunk_r [RESULT_BYTES];

  lzrle_job_t    job_r;
  logic          job_v_r;
  logic [11:0]   k_r;
  logic          b_v_r;
  logic          b_mem_r;
  logic          b_rev_r;
  logic [7:0]    b_val_r;
  logic [7:0]    mem_q_r;
  logic [AW-1:0] wptr_r;
  logic [FW-1:0] f_r;

  logic                      o_v_r;
  logic [RESULT_BYTES*8-1:0] o_data_r;
  logic [5:0]                o_count_r;
  logic                      o_last_r;
  logic [2:0]                o_status_r;
  logic [15:0]               o_cons_r;
  logic [14:0]               o_dec_r;

  logic          is_mem;
  logic          issued_all;
  logic          issue;
  logic          flush_cond;
  logic          flush_go;
  logic [7:0]    gen_byte;
  logic [7:0]    b_byte;
  logic [16:0]   rsum;
  logic [16:0]   rdif;
  logic [AW-1:0] raddr;
  logic [RESULT_BYTES*8-1:0] lanes;

  assign is_mem     = job_r.kind inside {K_FWD, K_REV, K_BACK};
  assign issued_all = (k_r == job_r.len);
  assign issue      = job_v_r && !issued_all &&
                      ((FW + 1)'(f_r) + (FW + 1)'(b_v_r) < (FW + 1)'(RESULT_BYTES));
  assign flush_cond = job_v_r && !b_v_r &&
                      (issued_all || f_r == FW'(RESULT_BYTES));
  assign flush_go   = flush_cond && (!o_v_r || res_ready);
  assign pop        = !job_v_r && !q_empty;
  assign rsum       = 17'(job_r.addr) + 17'(k_r);
  assign rdif       = 17'(job_r.addr) - 17'(k_r);
  assign raddr      = (job_r.kind == K_BACK) ? rdif[AW-1:0] : rsum[AW-1:0];
  assign b_byte     = b_mem_r ? (b_rev_r ? bitrev8(mem_q_r) : mem_q_r) : b_val_r;

  always_comb begin
    case (job_r.kind)
      K_PAIR:  gen_byte = k_r[0] ? job_r.val_b : job_r.val_a;
      K_INC:   gen_byte = job_r.val_a + k_r[7:0];
      default: gen_byte = job_r.val_a;
    endcase
  end

  always_comb begin
    for (int j = 0; j < RESULT_BYTES; j++) begin
      lanes[j*8 +: 8] = (FW'(j) < f_r) ? chunk_r[j] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (b_v_r) begin
      hist_mem[wptr_r] <= b_byte;
    end
    if (issue && is_mem) begin
      mem_q_r <= hist_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (b_v_r) begin
      chunk_r[f_r[IW-1:0]] <= b_byte;
    end
    if (pop) begin
      job_r <= head;
    end
    if (issue) begin
      b_mem_r <= is_mem;
      b_rev_r <= (job_r.kind == K_REV);
      b_val_r <= gen_byte;
    end
    if (flush_go) begin
      o_data_r   <= lanes;
      o_count_r  <= 6'(f_r);
      o_last_r   <= issued_all;
      o_status_r <= job_r.status;
      o_cons_r   <= job_r.consumed;
      o_dec_r    <= job_r.decompressed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
      k_r     <= '0;
      b_v_r   <= 1'b0;
      wptr_r  <= '0;
      f_r     <= '0;
      o_v_r   <= 1'b0;
    end else begin
      b_v_r <= issue;
      if (b_v_r) begin
        wptr_r <= wptr_r + AW'(1);
      end
      if (pop) begin
        job_v_r <= 1'b1;
        k_r     <= '0;
      end else if (issue) begin
        k_r <= k_r + 12'd1;
      end
      if (flush_go) begin
        f_r <= '0;
        if (issued_all) begin
          job_v_r <= 1'b0;
        end
      end else if (b_v_r) begin
        f_r <= f_r + FW'(1);
      end
      if (flush_go) begin
        o_v_r <= 1'b1;
      end else if (res_ready) begin
        o_v_r <= 1'b0;
      end
    end
  end

  assign res_valid        = o_v_r;
  assign res_data         = o_data_r;
  assign res_count        = o_count_r;
  assign res_last         = o_last_r;
  assign res_status       = o_status_r;
  assign res_consumed     = o_cons_r;
  assign res_decompressed = o_dec_r;

endmodule

### src/lz_rle_block_decompressor.sv
// LZ/RLE block decompressor.
// Input channel in_*: one compressed source byte per item, in_tlast marks the
// last source byte available. Output channel out_*: up to RESULT_BYTES decoded
// bytes per item, plus status, consumed source count and decompressed count;
// out_tlast marks the last output item caused by one source byte. Each source
// byte yields at least one output item (byte count zero if it decodes nothing).
// cfg_wr_en / cfg_wr_data set the output size limit (max_output).
// Throughput: the front decoder takes one source byte per cycle while its
// four-entry job queue has room. The back end produces one decoded byte per
// cycle (one history memory read per cycle for copies) while an output item
// is filling and the output register can accept it. It takes the next job
// from the queue only after the last output item of the current job has
// been registered.
// Reset clears the decoder state, the queue and the output register; the
// history memory needs no clearing. When out_tready is low the output
// register holds, the back end stops after filling one more item, and the
// front keeps taking source bytes until the queue fills.
module lz_rle_block_decompressor import lzrle_pkg::*; #(
  parameter int HISTORY_BYTES = DEF_HISTORY_BYTES,
  parameter int RESULT_BYTES  = DEF_RESULT_BYTES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [14:0]            cfg_wr_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // in_byte
  input  logic                   in_tlast,   // in_last
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // data_0, data_1, data_2, data_3, byte_count, status, consumed, decompressed
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast   // run_end
);

  lzrle_job_t front_job;
  lzrle_job_t head;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_empty;

  logic [RESULT_BYTES*8-1:0] res_data;
  logic [5:0]                res_count;
  logic [2:0]                res_status;
  logic [15:0]               res_consumed;
  logic [14:0]               res_decompressed;

  lzrle_front #(.HISTORY_BYTES(HISTORY_BYTES)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_tvalid),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .in_ready   (in_tready),
    .q_full     (q_full),
    .push       (push),
    .job        (front_job)
  );

  lzrle_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(front_job),
    .pop     (pop),
    .head    (head),
    .full    (q_full),
    .empty   (q_empty)
  );

  lzrle_back #(
    .HISTORY_BYTES(HISTORY_BYTES),
    .RESULT_BYTES (RESULT_BYTES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_empty         (q_empty),
    .pop             (pop),
    .res_valid       (out_tvalid),
    .res_ready       (out_tready),
    .res_data        (res_data),
    .res_count       (res_count),
    .res_last        (out_tlast),
    .res_status      (res_status),
    .res_consumed    (res_consumed),
    .res_decompressed(res_decompressed)
  );

  assign out_tdata = {res_decompressed, res_consumed, res_status, res_count,
                      LANE_BITS'(res_data)};

  a_full_unless_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[261:256] == 6'(RESULT_BYTES))
    else $error("non-final output item not full");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[261:256] <= 6'(RESULT_BYTES))
    else $error("byte count above item size");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[261:256] == 6'd0 |-> out_tlast)
    else $error("empty output item not marked last");

endmodule

### sim/lz_rle_block_decompressor_test.sv
module lz_rle_block_decompressor_test import lzrle_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_LIT  = 3'd0;
  localparam logic [2:0] CMD_FILL = 3'd1;
  localparam logic [2:0] CMD_PAIR = 3'd2;
  localparam logic [2:0] CMD_INC  = 3'd3;
  localparam logic [2:0] CMD_FWD  = 3'd4;
  localparam logic [2:0] CMD_REV  = 3'd5;
  localparam logic [2:0] CMD_BACK = 3'd6;
  localparam logic [2:0] CMD_EXT  = 3'd7;
  localparam logic [7:0] END_MARK = 8'hFF;
  localparam int HIST = 16384;

  typedef enum logic [2:0] {PH_CTRL, PH_EXT, PH_LIT, PH_ARG1, PH_ARG2, PH_STOP} phase_t;

  typedef struct {
    logic [7:0] b;
    logic       l;
  } src_t;

  typedef struct {
    logic [255:0] lanes;
    logic [5:0]   cnt;
    logic         last;
    logic [2:0]   status;
    logic [15:0]  consumed;
    logic [14:0]  decompressed;
  } chunk_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [14:0] cfg_wr_data;
  logic in_tvalid;
  logic in_tready;
  logic [7:0] in_tdata;
  logic in_tlast;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tlast;

  lz_rle_block_decompressor DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  src_t   src_q[$];
  chunk_t chunk_q[$];
  logic [7:0] step_bytes[$];

  logic [7:0] hist[HIST];
  int     out_cnt = 0;
  logic [15:0] src_cnt = 0;
  phase_t ph = PH_CTRL;
  logic [2:0] cmd = 0;
  int     rlen = 0;
  logic [7:0] a1 = 0, a2 = 0;
  int     max_lim = 16384;
  logic [2:0] sts = ST_BUSY;

  int gen_out = 0;
  int gen_lim = 16384;
  int n_src = 0;
  int n_out = 0;
  int errors = 0;
  bit in_took = 0;
  bit quiet = 0;
  bit pause = 0;
  int in_gap = 0;
  int rx_gap = 0;
  int hold_left = 0;
  bit hold_done = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  task put_byte(input logic [7:0] v);
    if (out_cnt < HIST) hist[out_cnt] = v;
    out_cnt++;
    step_bytes = {step_bytes, v};
  endtask

  task open_cmd(input logic [2:0] c, input int len);
    int need;
    int lim;
    need = (c == CMD_PAIR) ? 2 * len : len;
    lim = (max_lim < HIST) ? max_lim : HIST;
    if (out_cnt + need > lim) begin
      sts = ST_OVER;
    end else begin
      cmd = c;
      rlen = len;
      ph = (c == CMD_LIT) ? PH_LIT : PH_ARG1;
    end
  endtask

  task decode_item(input logic [7:0] b, input logic lst);
    int k, j, nres, cnt, adr;
    logic [7:0] v, r;
    chunk_t e;
    step_bytes = {};
    if (ph != PH_STOP) begin
      if (src_cnt != 16'hFFFF) src_cnt++;
      case (ph)
        PH_CTRL: begin
          if (b == END_MARK) begin
            sts = ST_DONE;
          end else if (b[7:5] == CMD_EXT) begin
            cmd = (b[4:2] == CMD_EXT) ? CMD_FWD : b[4:2];
            rlen = int'({b[1:0], 8'h00});
            ph = PH_EXT;
          end else begin
            open_cmd(b[7:5], int'(b[4:0]) + 1);
          end
        end
        PH_EXT: open_cmd(cmd, (rlen | int'(b)) + 1);
        PH_LIT: begin
          put_byte(b);
          rlen--;
          if (rlen == 0) ph = PH_CTRL;
        end
        PH_ARG1: begin
          a1 = b;
          if (cmd == CMD_FILL) begin
            for (k = 0; k < rlen; k++) put_byte(b);
            ph = PH_CTRL;
          end else if (cmd == CMD_INC) begin
            for (k = 0; k < rlen; k++) put_byte(b + k[7:0]);
            ph = PH_CTRL;
          end else begin
            ph = PH_ARG2;
          end
        end
        default: begin
          a2 = b;
          adr = int'({a1, a2});
          if (cmd == CMD_PAIR) begin
            for (k = 0; k < rlen; k++) begin
              put_byte(a1);
              put_byte(a2);
            end
            ph = PH_CTRL;
          end else if (cmd == CMD_BACK) begin
            if (adr < rlen - 1) sts = ST_LOW;
            else if (adr >= out_cnt) sts = ST_HIGH;
            else begin
              for (k = 0; k < rlen; k++) put_byte(hist[adr - k]);
              ph = PH_CTRL;
            end
          end else if (adr + rlen > out_cnt) begin
            sts = ST_HIGH;
          end else begin
            for (k = 0; k < rlen; k++) begin
              v = hist[adr + k];
              for (j = 0; j < 8; j++) r[j] = v[7 - j];
              put_byte(cmd == CMD_REV ? r : v);
            end
            ph = PH_CTRL;
          end
        end
      endcase
      if (sts == ST_BUSY && lst) sts = ST_TRUNC;
      if (sts != ST_BUSY) ph = PH_STOP;
    end
    nres = (step_bytes.size() == 0) ? 1 : (step_bytes.size() + 31) / 32;
    for (k = 0; k < nres; k++) begin
      cnt = step_bytes.size() - 32 * k;
      if (cnt < 0) cnt = 0;
      if (cnt > 32) cnt = 32;
      e.lanes = '0;
      for (j = 0; j < cnt; j++) e.lanes[8*j +: 8] = step_bytes[32*k + j];
      e.cnt = 6'(cnt);
      e.last = (k + 1 == nres);
      e.status = sts;
      e.consumed = src_cnt;
      e.decompressed = out_cnt[14:0];
      chunk_q = {chunk_q, e};
    end
  endtask

  always @(posedge clk) begin
    chunk_t e;
    in_took = in_tvalid && in_tready;
    if (in_took) decode_item(in_tdata, in_tlast);
    if (out_tvalid && out_tready) begin
      n_out++;
      if (chunk_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output item: %h", out_tdata);
      end else begin
        e = chunk_q.pop_front();
        if (out_tdata[255:0] !== e.lanes || out_tdata[261:256] !== e.cnt ||
            out_tlast !== e.last || out_tdata[264:262] !== e.status ||
            out_tdata[280:265] !== e.consumed || out_tdata[295:281] !== e.decompressed) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: exp cnt=%0d last=%0d st=%0d cons=%0d dec=%0d data=%h",
                     e.cnt, e.last, e.status, e.consumed, e.decompressed, e.lanes);
            $display("          got cnt=%0d last=%0d st=%0d cons=%0d dec=%0d data=%h",
                     out_tdata[261:256], out_tlast, out_tdata[264:262],
                     out_tdata[280:265], out_tdata[295:281], out_tdata[255:0]);
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    src_t it;
    if (!rst_n) begin
      in_tvalid <= 0;
    end else if (in_took || !in_tvalid) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 0;
      end else if (src_q.size() > 0 && !pause) begin
        it = src_q.pop_front();
        in_tdata <= it.b;
        in_tlast <= it.l;
        in_tvalid <= 1;
        if (!quiet && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 9);
      end else begin
        in_tvalid <= 0;
      end
    end
  end

  always @(negedge clk) begin
    if (!hold_done && n_out >= 200) begin
      hold_done = 1;
      hold_left = 400;
      out_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_tready <= 0;
    end else begin
      out_tready <= 1;
      if (!quiet && $urandom_range(0, 7) == 0) rx_gap = $urandom_range(1, 9);
    end
  end

  task push_src(input logic [7:0] v, input logic l);
    src_t it;
    it.b = v;
    it.l = l;
    src_q = {src_q, it};
    n_src++;
  endtask

  task send_cmd(input logic [2:0] c, input int len, input bit ext);
    int k, adr;
    logic [9:0] lm;
    lm = 10'(len - 1);
    if (ext) begin
      push_src({CMD_EXT, c, lm[9:8]}, 0);
      push_src(lm[7:0], 0);
    end else begin
      push_src({c, lm[4:0]}, 0);
    end
    case (c)
      CMD_LIT: for (k = 0; k < len; k++) push_src(8'($urandom_range(0, 255)), 0);
      CMD_FILL, CMD_INC: push_src(8'($urandom_range(0, 255)), 0);
      CMD_PAIR: begin
        push_src(8'($urandom_range(0, 255)), 0);
        push_src(8'($urandom_range(0, 255)), 0);
      end
      default: begin
        if (c == CMD_BACK) adr = $urandom_range(len - 1, gen_out - 1);
        else adr = $urandom_range(0, gen_out - len);
        push_src(adr[15:8], 0);
        push_src(adr[7:0], 0);
      end
    endcase
    gen_out += (c == CMD_PAIR) ? 2 * len : len;
  endtask

  task drain;
    while (src_q.size() != 0 || in_tvalid || chunk_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task write_limit(input logic [14:0] v);
    @(negedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 0;
    max_lim = int'(v);
  endtask

  initial begin
    int k, len, room;
    logic [2:0] c;
    bit ext;
    rst_n = 0;
    cfg_wr_en = 0;
    cfg_wr_data = 0;
    in_tvalid = 0;
    in_tdata = 0;
    in_tlast = 0;
    out_tready = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1;
    write_limit(15'd16384);

    send_cmd(CMD_LIT, 1, 0);
    send_cmd(CMD_LIT, 32, 0);
    send_cmd(CMD_FILL, 32, 0);
    send_cmd(CMD_FILL, 1, 0);
    send_cmd(CMD_PAIR, 5, 0);
    send_cmd(CMD_INC, 32, 0);
    send_cmd(CMD_FWD, 32, 0);
    send_cmd(CMD_REV, 8, 0);
    send_cmd(CMD_BACK, 1, 0);
    send_cmd(CMD_BACK, 32, 0);
    send_cmd(CMD_PAIR, 1024, 1);
    send_cmd(CMD_LIT, 3, 1);
    send_cmd(CMD_FILL, 1024, 1);
    send_cmd(CMD_INC, 300, 1);
    send_cmd(CMD_EXT, 768, 1);
    send_cmd(CMD_REV, 100, 1);
    send_cmd(CMD_BACK, 500, 1);
    send_cmd(CMD_FWD, 1, 1);

    drain();
    pause = 1;
    gen_lim = $urandom_range(gen_out + 7000, 16383);
    write_limit(gen_lim[14:0]);
    pause = 0;

    while (n_src < 380) begin
      c = 3'($urandom_range(0, 6));
      ext = ($urandom_range(0, 7) == 0);
      len = ext ? $urandom_range(1, 200) : $urandom_range(1, 32);
      room = gen_lim - gen_out - 8;
      if (c == CMD_PAIR) room = room / 2;
      if (c >= CMD_FWD && len > gen_out) len = gen_out;
      if (len > room) len = room;
      if (len < 1) break;
      if (ext && c == CMD_FWD && len <= 768 && $urandom_range(0, 1)) c = CMD_EXT;
      send_cmd(c, len, ext);
    end

    drain();
    quiet = 1;
    write_limit(15'd1);
    push_src({CMD_FILL, 5'd0}, 0);
    push_src(8'h00, 1);
    for (k = 0; k < 8; k++) push_src(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    drain();
    write_limit(15'h7FFF);
    for (k = 0; k < 8; k++) push_src(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    push_src(END_MARK, 1);
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
